// ===== hdl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BHT_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bht: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BHT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bht: next-cycle check failed");

`endif

// ===== hdl/bht_pkg.sv =====
package bht_pkg;

    localparam int BUCKETS   = 16;
    localparam int SLOTS     = 32;
    localparam int KEY_BYTES = 8;

    localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ADDR_W   = BUCKET_W + SLOT_W;
    localparam int ROWS     = 2 ** BUCKET_W;
    localparam int DEPTH    = 2 ** ADDR_W;

    localparam int OP_W     = 2;
    localparam int HASH_W   = 32;
    localparam int KEY_W    = 64;
    localparam int LEN_W    = 4;
    localparam int CNT_W    = 5;
    localparam int INDEX_W  = 4;

    localparam int DIV_STEPS = HASH_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [CNT_W-1:0] RESET_BUCKET_COUNT = CNT_W'(16);

    localparam logic [OP_W-1:0] OP_SEARCH = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [HASH_W-1:0] hash_value;
        logic [KEY_W-1:0]  key;
        logic [LEN_W-1:0]  key_length;
    } req_t;

    typedef struct packed {
        logic               success;
        logic [INDEX_W-1:0] bucket_index;
    } rsp_t;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] remainder;
    } mod_rsp_t;

endpackage

// ===== hdl/bht_in_if.sv =====
interface bht_in_if;

    logic          valid;
    logic          ready;
    bht_pkg::req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ===== hdl/bht_out_if.sv =====
interface bht_out_if;

    logic          valid;
    logic          ready;
    bht_pkg::rsp_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);

endinterface

// ===== hdl/bht_mod.sv =====
module bht_mod
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bht_pkg::HASH_W-1:0]    dividend,
    input  logic [bht_pkg::CNT_W-1:0]     divisor,
    output bht_pkg::mod_rsp_t             status
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [bht_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [bht_pkg::HASH_W-1:0]      shift_reg, shift_next;
    logic [bht_pkg::CNT_W-1:0]       rem_reg, rem_next;
    logic [bht_pkg::CNT_W-1:0]       div_reg, div_next;
    logic [bht_pkg::CNT_W-1:0]       rem_one;
    logic [bht_pkg::CNT_W-1:0]       rem_two;

    // One restoring step: the partial remainder stays below the divisor.
    function automatic logic [bht_pkg::CNT_W-1:0] rem_step
    (
        input logic [bht_pkg::CNT_W-1:0] r,
        input logic                      b,
        input logic [bht_pkg::CNT_W-1:0] d
    );
        logic [bht_pkg::CNT_W:0] t;
        t = {r, b};
        if (t >= {1'b0, d})
        begin
            t = t - {1'b0, d};
        end
        return t[bht_pkg::CNT_W-1:0];
    endfunction

    assign rem_one = rem_step(rem_reg, shift_reg[bht_pkg::HASH_W-1], div_reg);
    assign rem_two = rem_step(rem_one, shift_reg[bht_pkg::HASH_W-2], div_reg);

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        div_next   = div_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            shift_next = dividend;
            rem_next   = '0;
            div_next   = divisor;
        end
        else if (busy_reg)
        begin
            rem_next   = rem_two;
            shift_next = {shift_reg[bht_pkg::HASH_W-3:0], 2'b00};
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == bht_pkg::DIV_CNT_W'(bht_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
        div_reg   <= div_next;
    end

    assign status.done      = done_reg;
    assign status.remainder = rem_reg;

endmodule

// ===== hdl/bucketed_hash_table.sv =====
// An item rejected on length, operation or a zero bucket count goes straight to the
// result; otherwise the remainder unit computes the bucket, a bucket at or above 16
// fails, and any other goes through the slot scan (one slot per cycle) to the result.
// The block takes one item at a time and holds its result state on back-pressure.
// Reset: asynchronous, active low; a pass then clears the valid rows of all buckets,
// and no input transfer is taken until it ends.
module bucketed_hash_table
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [bht_pkg::CNT_W-1:0]    cfg_wdata,
    bht_in_if.sink                       req,
    bht_out_if.source                    rsp
);

    typedef enum logic [4:0]
    {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_DIV   = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_RESP  = 5'b10000
    } state_t;

    state_t                           state_reg, state_next;
    logic [bht_pkg::BUCKET_W-1:0]     clr_row_reg, clr_row_next;
    logic [bht_pkg::CNT_W-1:0]        bucket_count_reg, bucket_count_next;
    logic [bht_pkg::OP_W-1:0]         op_reg, op_next;
    logic [bht_pkg::KEY_W-1:0]        key_reg, key_next;
    logic [bht_pkg::LEN_W-1:0]        len_reg, len_next;
    logic [bht_pkg::BUCKET_W-1:0]     bucket_reg, bucket_next;
    logic [bht_pkg::SLOT_W-1:0]       issue_reg, issue_next;
    logic [bht_pkg::SLOT_W-1:0]       chk_reg, chk_next;
    logic                             chk_vld_reg, chk_vld_next;
    logic                             res_success_reg, res_success_next;
    logic                             rsp_valid_reg, rsp_valid_next;
    bht_pkg::rsp_t                    rsp_data_reg, rsp_data_next;

    logic [bht_pkg::KEY_W-1:0]        key_mem [bht_pkg::DEPTH];
    logic [bht_pkg::LEN_W-1:0]        len_mem [bht_pkg::DEPTH];
    logic [bht_pkg::SLOTS-1:0]        valid_mem [bht_pkg::ROWS];
    logic [bht_pkg::KEY_W-1:0]        key_rd_reg;
    logic [bht_pkg::LEN_W-1:0]        len_rd_reg;
    logic [bht_pkg::SLOTS-1:0]        valid_rd_reg;

    logic                             entry_we;
    logic                             row_we;
    logic [bht_pkg::BUCKET_W-1:0]     row_waddr;
    logic [bht_pkg::SLOTS-1:0]        row_wdata;
    logic [bht_pkg::ADDR_W-1:0]       entry_raddr;
    logic [bht_pkg::ADDR_W-1:0]       entry_waddr;

    logic                             accept;
    logic                             early_fail;
    logic                             mod_start;
    logic [bht_pkg::KEY_W-1:0]        key_masked;
    logic [bht_pkg::SLOTS-1:0]        slot_bit;
    logic                             slot_valid;
    logic                             hit;
    bht_pkg::mod_rsp_t                mod_status;

    bht_mod u_mod
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (req.data.hash_value),
        .divisor  (bucket_count_reg),
        .status   (mod_status)
    );

    assign req.ready = (state_reg == ST_IDLE);
    assign accept    = req.valid && req.ready;

    assign early_fail = (req.data.key_length == '0)
        || (req.data.key_length > bht_pkg::LEN_W'(bht_pkg::KEY_BYTES))
        || (bucket_count_reg == '0)
        || (req.data.operation == bht_pkg::OP_NONE);
    assign mod_start = accept && !early_fail;

    always_comb
    begin
        key_masked = '0;
        for (int i = 0; i < bht_pkg::KEY_BYTES; i++)
        begin
            if (bht_pkg::LEN_W'(i) < req.data.key_length)
            begin
                key_masked[8*i +: 8] = req.data.key[8*i +: 8];
            end
        end
    end

    assign entry_raddr = {bucket_reg, issue_reg};
    assign entry_waddr = {bucket_reg, chk_reg};
    assign slot_bit    = bht_pkg::SLOTS'(1) << chk_reg;
    assign slot_valid  = valid_rd_reg[chk_reg];

    always_comb
    begin
        if (op_reg == bht_pkg::OP_INSERT)
        begin
            hit = !slot_valid;
        end
        else
        begin
            hit = slot_valid && (len_rd_reg == len_reg) && (key_rd_reg == key_reg);
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_row_next      = clr_row_reg;
        bucket_count_next = cfg_we ? cfg_wdata : bucket_count_reg;
        op_next           = op_reg;
        key_next          = key_reg;
        len_next          = len_reg;
        bucket_next       = bucket_reg;
        issue_next        = issue_reg;
        chk_next          = chk_reg;
        chk_vld_next      = chk_vld_reg;
        res_success_next  = res_success_reg;
        rsp_valid_next    = rsp_valid_reg && !rsp.ready;
        rsp_data_next     = rsp_data_reg;
        entry_we          = 1'b0;
        row_we            = 1'b0;
        row_waddr         = bucket_reg;
        row_wdata         = valid_rd_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                row_we       = 1'b1;
                row_waddr    = clr_row_reg;
                row_wdata    = '0;
                clr_row_next = clr_row_reg + 1'b1;
                if (clr_row_reg == bht_pkg::BUCKET_W'(bht_pkg::ROWS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next          = req.data.operation;
                    key_next         = key_masked;
                    len_next         = req.data.key_length;
                    res_success_next = 1'b0;
                    state_next       = early_fail ? ST_RESP : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (mod_status.done)
                begin
                    issue_next   = '0;
                    chk_vld_next = 1'b0;
                    if (int'(mod_status.remainder) >= bht_pkg::BUCKETS)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        bucket_next = bht_pkg::BUCKET_W'(mod_status.remainder);
                        state_next  = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (chk_vld_reg && hit)
                begin
                    res_success_next = 1'b1;
                    row_we           = 1'b1;
                    state_next       = ST_RESP;
                    if (op_reg == bht_pkg::OP_INSERT)
                    begin
                        entry_we  = 1'b1;
                        row_wdata = valid_rd_reg | slot_bit;
                    end
                    else if (op_reg == bht_pkg::OP_REMOVE)
                    begin
                        row_wdata = valid_rd_reg & ~slot_bit;
                    end
                    else
                    begin
                        row_we = 1'b0;
                    end
                end
                else if (chk_vld_reg && chk_reg == bht_pkg::SLOT_W'(bht_pkg::SLOTS - 1))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    chk_next     = issue_reg;
                    chk_vld_next = 1'b1;
                    if (issue_reg != bht_pkg::SLOT_W'(bht_pkg::SLOTS - 1))
                    begin
                        issue_next = issue_reg + 1'b1;
                    end
                end
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next             = 1'b1;
                    rsp_data_next.success      = res_success_reg;
                    rsp_data_next.bucket_index = res_success_reg
                        ? bht_pkg::INDEX_W'(bucket_reg) : '0;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_CLEAR;
            clr_row_reg      <= '0;
            bucket_count_reg <= bht_pkg::RESET_BUCKET_COUNT;
            chk_vld_reg      <= 1'b0;
            rsp_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_row_reg      <= clr_row_next;
            bucket_count_reg <= bucket_count_next;
            chk_vld_reg      <= chk_vld_next;
            rsp_valid_reg    <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg          <= op_next;
        key_reg         <= key_next;
        len_reg         <= len_next;
        bucket_reg      <= bucket_next;
        issue_reg       <= issue_next;
        chk_reg         <= chk_next;
        res_success_reg <= res_success_next;
        rsp_data_reg    <= rsp_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            key_mem[entry_waddr] <= key_reg;
            len_mem[entry_waddr] <= len_reg;
        end
        key_rd_reg <= key_mem[entry_raddr];
        len_rd_reg <= len_mem[entry_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            valid_mem[row_waddr] <= row_wdata;
        end
        valid_rd_reg <= valid_mem[bucket_reg];
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

// ===== hdl/bht_checker.sv =====
`include "assert_macros.svh"

module bht_checker
(
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic                            rsp_success,
    input logic [bht_pkg::INDEX_W-1:0]     rsp_bucket_index
);

    // A stalled result keeps its contents until the transfer.
    `BHT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_success) && $stable(rsp_bucket_index))

    // A failed operation reports bucket zero.
    `BHT_ASSERT(a_fail_bucket_zero, rsp_valid && !rsp_success, rsp_bucket_index == '0)

    // The block works on one operation at a time.
    `BHT_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)

endmodule

bind bucketed_hash_table bht_checker u_bht_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_success      (rsp.data.success),
    .rsp_bucket_index (rsp.data.bucket_index)
);

// ===== verif/bucketed_hash_table_test.sv =====
module bucketed_hash_table_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bht_pkg::*;

    localparam int POOL = 10;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CNT_W-1:0] cfg_wdata;

    bht_in_if  req_ch ();
    bht_out_if rsp_ch ();

    bucketed_hash_table uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    always #4 clk = ~clk;

    // Shadow copy of the table contents and the divisor register.
    logic             slot_used  [DEPTH];
    logic [KEY_W-1:0] slot_bytes [DEPTH];
    logic [LEN_W-1:0] slot_len   [DEPTH];
    logic [CNT_W-1:0] div_count;

    rsp_t op_outcomes [$];
    int   fail_count = 0;
    int   burst_left = 0;

    function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        if (len >= 8)
        begin
            return '1;
        end
        return (64'd1 << (len * 8)) - 64'd1;
    endfunction

    function automatic rsp_t apply_table_op(input req_t r);
        rsp_t             res;
        logic [KEY_W-1:0] k;
        int unsigned      bucket;
        int unsigned      at;
        bit               ok;
        res = '0;
        ok = 1'b0;
        if (r.key_length == 0 || r.key_length > KEY_BYTES || div_count == 0
            || r.operation == OP_NONE)
        begin
            return res;
        end
        bucket = r.hash_value % div_count;
        if (bucket >= BUCKETS)
        begin
            return res;
        end
        k = r.key & byte_mask(r.key_length);
        for (int s = 0; s < SLOTS && !ok; s++)
        begin
            at = bucket * SLOTS + s;
            if (r.operation == OP_INSERT)
            begin
                if (!slot_used[at])
                begin
                    slot_used[at] = 1'b1;
                    slot_bytes[at] = k;
                    slot_len[at] = r.key_length;
                    ok = 1'b1;
                end
            end
            else if (slot_used[at] && slot_len[at] == r.key_length && slot_bytes[at] == k)
            begin
                if (r.operation == OP_REMOVE)
                begin
                    slot_used[at] = 1'b0;
                end
                ok = 1'b1;
            end
        end
        if (ok)
        begin
            res.success = 1'b1;
            res.bucket_index = INDEX_W'(bucket);
        end
        return res;
    endfunction

    task automatic send_req(input logic [OP_W-1:0] op, input logic [HASH_W-1:0] hash,
                            input logic [KEY_W-1:0] key, input logic [LEN_W-1:0] len);
        req_t item;
        int   gap;
        item.operation = op;
        item.hash_value = hash;
        item.key = key;
        item.key_length = len;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            repeat (gap) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
        end
        req_ch.data  <= item;
        req_ch.valid <= 1'b1;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
        op_outcomes.push_back(apply_table_op(item));
        burst_left--;
        if (burst_left == 0)
        begin
            req_ch.valid <= 1'b0;
        end
    endtask

    task automatic end_burst();
        if (burst_left != 0)
        begin
            req_ch.valid <= 1'b0;
            burst_left = 0;
        end
    endtask

    task automatic wait_all_results();
        end_burst();
        while (op_outcomes.size() != 0) @(posedge clk);
    endtask

    task automatic write_bucket_count(input logic [CNT_W-1:0] count);
        wait_all_results();
        @(posedge clk);
        cfg_wdata <= count;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        div_count = count;
    endtask

    task automatic test_empty_table();
        send_req(OP_SEARCH, 32'h0, 64'h0, 4'd1);
        send_req(OP_REMOVE, 32'hFFFF_FFFF, '1, 4'd8);
    endtask

    task automatic test_basic_ops();
        send_req(OP_INSERT, 32'd5, '1, 4'd8);
        send_req(OP_SEARCH, 32'd5, '1, 4'd8);
        send_req(OP_SEARCH, 32'd5, '1, 4'd7);
        send_req(OP_INSERT, 32'hFFFF_FFFF, 64'hDEAD_BEEF_0000_00A5, 4'd1);
        send_req(OP_SEARCH, 32'hFFFF_FFFF, 64'h1234_5678_9ABC_DEA5, 4'd1);
        send_req(OP_REMOVE, 32'hFFFF_FFFF, 64'h0000_0000_0000_00A5, 4'd1);
        send_req(OP_SEARCH, 32'hFFFF_FFFF, 64'h0000_0000_0000_00A5, 4'd1);
        send_req(OP_REMOVE, 32'd5, '1, 4'd8);
        send_req(OP_INSERT, 32'h0, 64'h0, 4'd8);
        send_req(OP_SEARCH, 32'h0, 64'h0, 4'd8);
    endtask

    task automatic test_special_cases();
        send_req(OP_INSERT, 32'd7, 64'h11, 4'd0);
        send_req(OP_INSERT, 32'd7, 64'h11, 4'd9);
        send_req(OP_SEARCH, 32'd7, '1, 4'd15);
        send_req(OP_NONE, 32'd0, 64'h0, 4'd8);
        write_bucket_count(5'd0);
        send_req(OP_INSERT, 32'd3, 64'h22, 4'd2);
        write_bucket_count(5'd31);
        send_req(OP_INSERT, 32'd20, 64'h33, 4'd3);
        send_req(OP_INSERT, 32'd31, 64'h44, 4'd4);
        write_bucket_count(5'd17);
        send_req(OP_INSERT, 32'd16, 64'h55, 4'd5);
        send_req(OP_SEARCH, 32'd31, 64'h44, 4'd4);
    endtask

    task automatic test_full_bucket();
        logic [KEY_W-1:0] first_key;
        logic [KEY_W-1:0] k;
        write_bucket_count(5'd1);
        first_key = {$urandom, $urandom};
        send_req(OP_INSERT, $urandom, first_key, 4'd8);
        for (int i = 1; i < SLOTS + 2; i++)
        begin
            k = {$urandom, $urandom};
            send_req(OP_INSERT, $urandom, k, 4'd8);
        end
        send_req(OP_REMOVE, $urandom, first_key, 4'd8);
        send_req(OP_INSERT, $urandom, {$urandom, $urandom}, 4'd8);
        send_req(OP_INSERT, $urandom, {$urandom, $urandom}, 4'd8);
        send_req(OP_SEARCH, $urandom, k, 4'd8);
        send_req(OP_SEARCH, $urandom, first_key, 4'd8);
    endtask

    task automatic run_random_phase(input logic [CNT_W-1:0] count, input int n,
                                    input bit hold_midway);
        logic [KEY_W-1:0]  pkey  [POOL];
        logic [HASH_W-1:0] phash [POOL];
        logic [LEN_W-1:0]  plen  [POOL];
        logic [KEY_W-1:0]  k;
        logic [LEN_W-1:0]  l;
        int                p;
        int                pick;
        write_bucket_count(count);
        for (int i = 0; i < POOL; i++)
        begin
            plen[i] = ($urandom_range(0, 3) == 0) ? 4'd8 : LEN_W'($urandom_range(1, 8));
            pkey[i] = {$urandom, $urandom} & byte_mask(plen[i]);
            phash[i] = ($urandom_range(0, 1) == 1) ? HASH_W'($urandom)
                                                   : HASH_W'($urandom_range(0, 40));
        end
        for (int i = 0; i < n; i++)
        begin
            if (hold_midway && i == n / 2)
            begin
                wait_all_results();
            end
            p = $urandom_range(0, POOL - 1);
            pick = $urandom_range(0, 99);
            k = pkey[p];
            l = plen[p];
            if ($urandom_range(0, 2) == 0)
            begin
                k = k | ({$urandom, $urandom} & ~byte_mask(l));
            end
            if (pick < 12)
            begin
                send_req(OP_W'($urandom_range(0, 3)), $urandom, {$urandom, $urandom},
                         LEN_W'($urandom_range(0, 15)));
            end
            else if (pick < 16)
            begin
                send_req(OP_SEARCH, phash[p], k, LEN_W'($urandom_range(1, 8)));
            end
            else if (pick < 48)
            begin
                send_req(OP_INSERT, phash[p], k, l);
            end
            else if (pick < 76)
            begin
                send_req(OP_SEARCH, phash[p], k, l);
            end
            else
            begin
                send_req(OP_REMOVE, phash[p], k, l);
            end
        end
    endtask

    task automatic test_random_phases();
        logic [CNT_W-1:0] counts [11];
        counts = '{5'd16, 5'd2, 5'd1, 5'd5, 5'd31, 5'd0, 5'd16, 5'd3, 5'd17, 5'd1, 5'd16};
        for (int i = 0; i < 11; i++)
        begin
            run_random_phase(counts[i], (counts[i] == 0) ? 40 : 120, i == 3);
        end
    endtask

    // Result checker and receiver stall pattern.
    initial
    begin
        rsp_t got;
        rsp_t want;
        int   stall_mode;
        int   mode_left;
        logic rdy;
        stall_mode = 0;
        mode_left = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got = rsp_ch.data;
                if (op_outcomes.size() == 0)
                begin
                    $error("unexpected result transfer: success %0d, bucket_index %0d",
                           got.success, got.bucket_index);
                    fail_count++;
                end
                else
                begin
                    want = op_outcomes.pop_front();
                    if (got.success !== want.success)
                    begin
                        $error("success: expected %0d, actual %0d", want.success, got.success);
                        fail_count++;
                    end
                    if (got.bucket_index !== want.bucket_index)
                    begin
                        $error("bucket_index: expected %0d, actual %0d",
                               want.bucket_index, got.bucket_index);
                        fail_count++;
                    end
                end
            end
            if (mode_left == 0)
            begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (stall_mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                2: rdy = (mode_left % 4) == 0;
                default: rdy = (mode_left % 32) == 0;
            endcase
            rsp_ch.ready <= rdy;
        end
    end

    initial
    begin
        #8_000_000;
        $display("bucketed_hash_table_test: done, errors");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            slot_used[i] = 1'b0;
        end
        div_count = RESET_BUCKET_COUNT;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_wdata    <= '0;
        req_ch.valid <= 1'b0;
        req_ch.data  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_table();
        test_basic_ops();
        test_special_cases();
        test_full_bucket();
        test_random_phases();
        wait_all_results();
        repeat (80) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("bucketed_hash_table_test: done, clean");
        end
        else
        begin
            $display("bucketed_hash_table_test: done, errors");
        end
        $finish;
    end

endmodule
